// File: src/leb_pkg.sv
`timescale 1ns / 1ps

package leb_pkg;

  // Default line capacity in characters
  localparam int unsigned LINE_CAP_DEF = 256;

  // Character width
  localparam int unsigned CHAR_W = 8;

  typedef enum logic [3:0] {
    OP_INSERT     = 4'd0,
    OP_DEL_BACK   = 4'd1,
    OP_DEL_FWD    = 4'd2,
    OP_TRANSPOSE  = 4'd3,
    OP_LEFT       = 4'd4,
    OP_RIGHT      = 4'd5,
    OP_HOME       = 4'd6,
    OP_END        = 4'd7,
    OP_WORD_LEFT  = 4'd8,
    OP_WORD_RIGHT = 4'd9,
    OP_KILL_END   = 4'd10,
    OP_KILL_START = 4'd11,
    OP_KILL_WORD  = 4'd12,
    OP_YANK       = 4'd13,
    OP_CLEAR      = 4'd14,
    OP_READ       = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_SHR,
    S_SHL,
    S_TOYANK,
    S_FROMYANK,
    S_SWAP,
    S_SCANB,
    S_SCANF,
    S_READ,
    S_DONE
  } state_e;

  // Letters, digits and underscore form words
  function automatic logic word_byte(input logic [CHAR_W-1:0] c);
    word_byte = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
                (c >= 8'h61 && c <= 8'h7a) || (c == 8'h5f);
  endfunction

endpackage

// File: src/leb_ram.sv
`timescale 1ns / 1ps

module leb_ram #(
  parameter int unsigned DEPTH = leb_pkg::LINE_CAP_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [leb_pkg::CHAR_W-1:0]  wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [leb_pkg::CHAR_W-1:0]  rdata_o
);

  logic [leb_pkg::CHAR_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/line_edit_buffer_core.sv
`timescale 1ns / 1ps

// Line editing buffer with cursor and kill/yank store.
// Input channel: in_valid_i with operation_i, char_in_i, read_index_i; a transfer
// happens when in_valid_i is high and in_stall_o is low. Each command gives one
// result on the output channel (status_o, cursor_pos_o, line_length_o, char_out_o),
// transferred when out_valid_o is high and out_stall_i is low.
// Commands are handled one at a time by a sequencer around two line/yank
// memories, each with one write and one read port and registered reads;
// each moved or scanned character takes a read, then a write or a test.
// in_stall_o stays high while a command is at work. One finished result
// is held in the output register; a stalled receiver keeps it there and
// the sequencer waits with the next result until it is taken. Reset empties
// the line and the yank store and sets insert mode; no memory clearing is
// needed. cfg_we_i/cfg_wdata_i write insert_enable; the user must do so only
// while idle, as the block itself does not enforce it.
module line_edit_buffer_core #(
  parameter int unsigned LINE_CAP = leb_pkg::LINE_CAP_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] operation_i,
  input  logic [7:0] char_in_i,
  input  logic [7:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [8:0] cursor_pos_o,
  output logic [8:0] line_length_o,
  output logic [7:0] char_out_o
);

  localparam int unsigned AW = $clog2(LINE_CAP);
  localparam int unsigned LW = $clog2(LINE_CAP + 1);
  localparam int unsigned CW = (LW > 8) ? LW : 8;
  localparam logic [LW-1:0] CAP = LW'(LINE_CAP);
  localparam logic [LW-1:0] ONE = LW'(1);
  localparam logic [LW-1:0] TWO = LW'(2);

  leb_pkg::state_e state_q, state_d;
  leb_pkg::op_e    op_q, op_d;
  leb_pkg::status_e st_q, st_d;
  logic [LW-1:0] cur_q, cur_d, len_q, len_d, ylen_q, ylen_d;
  logic [LW-1:0] idx_q, idx_d, n_q, n_d, pos_q, pos_d;
  logic [1:0]    ph_q, ph_d;
  logic          sk_q, sk_d;
  logic          ins_en_q;
  logic [7:0]    ch_q, ch_d, ridx_q, ridx_d, tmp_q, tmp_d, cout_q, cout_d;
  logic          out_valid_q, out_load;
  logic [1:0]    status_q;
  logic [8:0]    ocur_q, olen_q;
  logic [7:0]    ochar_q;
  logic          scan_fin;
  logic [CW-1:0] ridx_w, len_w;
  logic [LW+8:0] cur_x, len_x;

  logic          line_we, yank_we;
  logic [AW-1:0] line_waddr, line_raddr, yank_waddr, yank_raddr;
  logic [7:0]    line_wdata, line_rdata, yank_wdata, yank_rdata;

  leb_ram #(.DEPTH(LINE_CAP)) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (line_we),
    .waddr_i(line_waddr),
    .wdata_i(line_wdata),
    .raddr_i(line_raddr),
    .rdata_o(line_rdata)
  );

  leb_ram #(.DEPTH(LINE_CAP)) u_yank_ram (
    .clk_i  (clk_i),
    .we_i   (yank_we),
    .waddr_i(yank_waddr),
    .wdata_i(yank_wdata),
    .raddr_i(yank_raddr),
    .rdata_o(yank_rdata)
  );

  assign ridx_w = CW'(ridx_q);
  assign len_w  = CW'(len_q);
  assign cur_x  = (LW + 9)'(cur_q);
  assign len_x  = (LW + 9)'(len_q);

  assign in_stall_o = (state_q != leb_pkg::S_IDLE);

  // Sequencer: next state, memory access and state updates
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    st_d       = st_q;
    cur_d      = cur_q;
    len_d      = len_q;
    ylen_d     = ylen_q;
    idx_d      = idx_q;
    n_d        = n_q;
    pos_d      = pos_q;
    ph_d       = ph_q;
    sk_d       = sk_q;
    ch_d       = ch_q;
    ridx_d     = ridx_q;
    tmp_d      = tmp_q;
    cout_d     = cout_q;
    out_load   = 1'b0;
    scan_fin   = 1'b0;
    line_we    = 1'b0;
    line_waddr = '0;
    line_wdata = '0;
    line_raddr = '0;
    yank_we    = 1'b0;
    yank_waddr = '0;
    yank_wdata = '0;
    yank_raddr = '0;

    case (state_q)
      leb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d    = leb_pkg::op_e'(operation_i);
          ch_d    = char_in_i;
          ridx_d  = read_index_i;
          state_d = leb_pkg::S_DEC;
        end
      end

      leb_pkg::S_DEC: begin
        st_d    = leb_pkg::ST_OK;
        cout_d  = '0;
        ph_d    = '0;
        sk_d    = 1'b0;
        idx_d   = '0;
        state_d = leb_pkg::S_DONE;
        case (op_q)
          leb_pkg::OP_INSERT: begin
            if (ins_en_q || cur_q >= len_q) begin
              if (len_q >= CAP) begin
                st_d = leb_pkg::ST_FULL;
              end else begin
                idx_d   = len_q;
                n_d     = ONE;
                state_d = leb_pkg::S_SHR;
              end
            end else begin
              line_we    = 1'b1;
              line_waddr = AW'(cur_q);
              line_wdata = ch_q;
              cur_d      = cur_q + ONE;
            end
          end
          leb_pkg::OP_DEL_BACK: begin
            if (cur_q == '0) begin
              st_d = leb_pkg::ST_REFUSED;
            end else begin
              idx_d   = cur_q;
              n_d     = ONE;
              cur_d   = cur_q - ONE;
              state_d = leb_pkg::S_SHL;
            end
          end
          leb_pkg::OP_DEL_FWD: begin
            if (cur_q >= len_q) begin
              st_d = leb_pkg::ST_REFUSED;
            end else begin
              idx_d   = cur_q + ONE;
              n_d     = ONE;
              state_d = leb_pkg::S_SHL;
            end
          end
          leb_pkg::OP_TRANSPOSE: begin
            if (len_q < TWO) begin
              st_d = leb_pkg::ST_REFUSED;
            end else if (cur_q >= len_q) begin
              pos_d   = len_q - TWO;
              state_d = leb_pkg::S_SWAP;
            end else if (cur_q != '0) begin
              pos_d   = cur_q - ONE;
              cur_d   = cur_q + ONE;
              state_d = leb_pkg::S_SWAP;
            end else begin
              st_d = leb_pkg::ST_REFUSED;
            end
          end
          leb_pkg::OP_LEFT: begin
            if (cur_q == '0) st_d = leb_pkg::ST_REFUSED;
            else cur_d = cur_q - ONE;
          end
          leb_pkg::OP_RIGHT: begin
            if (cur_q >= len_q) st_d = leb_pkg::ST_REFUSED;
            else cur_d = cur_q + ONE;
          end
          leb_pkg::OP_HOME: cur_d = '0;
          leb_pkg::OP_END:  cur_d = len_q;
          leb_pkg::OP_WORD_LEFT, leb_pkg::OP_KILL_WORD: begin
            if (cur_q == '0) begin
              st_d = leb_pkg::ST_REFUSED;
            end else begin
              pos_d   = cur_q;
              state_d = leb_pkg::S_SCANB;
            end
          end
          leb_pkg::OP_WORD_RIGHT: begin
            if (cur_q >= len_q) begin
              st_d = leb_pkg::ST_REFUSED;
            end else begin
              pos_d   = cur_q;
              state_d = leb_pkg::S_SCANF;
            end
          end
          leb_pkg::OP_KILL_END: begin
            pos_d   = cur_q;
            n_d     = len_q - cur_q;
            state_d = leb_pkg::S_TOYANK;
          end
          leb_pkg::OP_KILL_START: begin
            if (cur_q != '0) begin
              pos_d   = '0;
              n_d     = cur_q;
              state_d = leb_pkg::S_TOYANK;
            end
          end
          leb_pkg::OP_YANK: begin
            if (ylen_q == '0) begin
              st_d = leb_pkg::ST_REFUSED;
            end else if (ylen_q > CAP - len_q) begin
              st_d = leb_pkg::ST_FULL;
            end else begin
              idx_d   = len_q;
              n_d     = ylen_q;
              state_d = leb_pkg::S_SHR;
            end
          end
          leb_pkg::OP_CLEAR: begin
            len_d = '0;
            cur_d = '0;
          end
          leb_pkg::OP_READ: begin
            if (ridx_w < len_w) begin
              line_raddr = AW'(ridx_w);
              state_d    = leb_pkg::S_READ;
            end else begin
              st_d = leb_pkg::ST_REFUSED;
            end
          end
          default: st_d = leb_pkg::ST_REFUSED;
        endcase
      end

      // Open a gap of n at the cursor, walking down from the line end
      leb_pkg::S_SHR: begin
        if (ph_q == 2'd0) begin
          if (idx_q == cur_q) begin
            if (op_q == leb_pkg::OP_INSERT) begin
              line_we    = 1'b1;
              line_waddr = AW'(cur_q);
              line_wdata = ch_q;
              len_d      = len_q + ONE;
              cur_d      = cur_q + ONE;
              state_d    = leb_pkg::S_DONE;
            end else begin
              idx_d   = '0;
              state_d = leb_pkg::S_FROMYANK;
            end
          end else begin
            line_raddr = AW'(idx_q - ONE);
            ph_d       = 2'd1;
          end
        end else begin
          line_we    = 1'b1;
          line_waddr = AW'(idx_q - ONE + n_q);
          line_wdata = line_rdata;
          idx_d      = idx_q - ONE;
          ph_d       = 2'd0;
        end
      end

      // Close a gap of n, walking up to the line end
      leb_pkg::S_SHL: begin
        if (ph_q == 2'd0) begin
          if (idx_q == len_q) begin
            len_d   = len_q - n_q;
            state_d = leb_pkg::S_DONE;
          end else begin
            line_raddr = AW'(idx_q);
            ph_d       = 2'd1;
          end
        end else begin
          line_we    = 1'b1;
          line_waddr = AW'(idx_q - n_q);
          line_wdata = line_rdata;
          idx_d      = idx_q + ONE;
          ph_d       = 2'd0;
        end
      end

      // Copy n characters from pos into the yank store, then cut them from the line
      leb_pkg::S_TOYANK: begin
        if (ph_q == 2'd0) begin
          if (idx_q == n_q) begin
            ylen_d = n_q;
            if (op_q == leb_pkg::OP_KILL_END) begin
              len_d   = cur_q;
              state_d = leb_pkg::S_DONE;
            end else begin
              idx_d   = cur_q;
              cur_d   = pos_q;
              state_d = leb_pkg::S_SHL;
            end
          end else begin
            line_raddr = AW'(pos_q + idx_q);
            ph_d       = 2'd1;
          end
        end else begin
          yank_we    = 1'b1;
          yank_waddr = AW'(idx_q);
          yank_wdata = line_rdata;
          idx_d      = idx_q + ONE;
          ph_d       = 2'd0;
        end
      end

      // Fill the gap at the cursor from the yank store
      leb_pkg::S_FROMYANK: begin
        if (ph_q == 2'd0) begin
          if (idx_q == n_q) begin
            len_d   = len_q + n_q;
            cur_d   = cur_q + n_q;
            state_d = leb_pkg::S_DONE;
          end else begin
            yank_raddr = AW'(idx_q);
            ph_d       = 2'd1;
          end
        end else begin
          line_we    = 1'b1;
          line_waddr = AW'(cur_q + idx_q);
          line_wdata = yank_rdata;
          idx_d      = idx_q + ONE;
          ph_d       = 2'd0;
        end
      end

      // Swap the characters at pos and pos+1
      leb_pkg::S_SWAP: begin
        case (ph_q)
          2'd0: begin
            line_raddr = AW'(pos_q);
            ph_d       = 2'd1;
          end
          2'd1: begin
            tmp_d      = line_rdata;
            line_raddr = AW'(pos_q + ONE);
            ph_d       = 2'd2;
          end
          2'd2: begin
            line_we    = 1'b1;
            line_waddr = AW'(pos_q);
            line_wdata = line_rdata;
            ph_d       = 2'd3;
          end
          default: begin
            line_we    = 1'b1;
            line_waddr = AW'(pos_q + ONE);
            line_wdata = tmp_q;
            state_d    = leb_pkg::S_DONE;
          end
        endcase
      end

      // Backward scan: separators, then word characters
      leb_pkg::S_SCANB: begin
        if (ph_q == 2'd0) begin
          if (pos_q == '0) begin
            scan_fin = 1'b1;
          end else begin
            line_raddr = AW'(pos_q - ONE);
            ph_d       = 2'd1;
          end
        end else begin
          ph_d = 2'd0;
          if (!sk_q) begin
            pos_d = pos_q - ONE;
            if (leb_pkg::word_byte(line_rdata)) sk_d = 1'b1;
          end else if (leb_pkg::word_byte(line_rdata)) begin
            pos_d = pos_q - ONE;
          end else begin
            scan_fin = 1'b1;
          end
        end
        if (scan_fin) begin
          if (op_q == leb_pkg::OP_KILL_WORD) begin
            n_d     = cur_q - pos_q;
            idx_d   = '0;
            ph_d    = 2'd0;
            state_d = leb_pkg::S_TOYANK;
          end else begin
            cur_d   = pos_q;
            state_d = leb_pkg::S_DONE;
          end
        end
      end

      // Forward scan: word characters, then separators
      leb_pkg::S_SCANF: begin
        if (ph_q == 2'd0) begin
          if (pos_q == len_q) begin
            scan_fin = 1'b1;
          end else begin
            line_raddr = AW'(pos_q);
            ph_d       = 2'd1;
          end
        end else begin
          ph_d = 2'd0;
          if (!sk_q) begin
            pos_d = pos_q + ONE;
            if (!leb_pkg::word_byte(line_rdata)) sk_d = 1'b1;
          end else if (!leb_pkg::word_byte(line_rdata)) begin
            pos_d = pos_q + ONE;
          end else begin
            scan_fin = 1'b1;
          end
        end
        if (scan_fin) begin
          cur_d   = pos_q;
          state_d = leb_pkg::S_DONE;
        end
      end

      leb_pkg::S_READ: begin
        cout_d  = line_rdata;
        state_d = leb_pkg::S_DONE;
      end

      // Hand the result to the output register once it is free
      leb_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = leb_pkg::S_IDLE;
        end
      end

      default: state_d = leb_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= leb_pkg::S_IDLE;
      cur_q       <= '0;
      len_q       <= '0;
      ylen_q      <= '0;
      ins_en_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      len_q       <= len_d;
      ylen_q      <= ylen_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
      if (cfg_we_i) begin
        ins_en_q <= cfg_wdata_i;
      end
    end
  end

  // Work registers and result payload
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    st_q   <= st_d;
    idx_q  <= idx_d;
    n_q    <= n_d;
    pos_q  <= pos_d;
    ph_q   <= ph_d;
    sk_q   <= sk_d;
    ch_q   <= ch_d;
    ridx_q <= ridx_d;
    tmp_q  <= tmp_d;
    cout_q <= cout_d;
    if (out_load) begin
      status_q <= st_q;
      ocur_q   <= cur_x[8:0];
      olen_q   <= len_x[8:0];
      ochar_q  <= cout_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign cursor_pos_o  = ocur_q;
  assign line_length_o = olen_q;
  assign char_out_o    = ochar_q;

  // Cursor stays within the line
  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_q <= len_q)
    else $error("cursor beyond line end");

  // Line and yank store never exceed capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= CAP && ylen_q <= CAP)
    else $error("length beyond capacity");

  // A result is only loaded from the completion state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> state_q == leb_pkg::S_DONE && state_d == leb_pkg::S_IDLE)
    else $error("result loaded outside completion");

  // Delivered status is a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status delivered");

endmodule

// File: bench/line_edit_buffer_core_tb.sv
`timescale 1ns / 1ps

module line_edit_buffer_core_tb;

  localparam int unsigned CAP = 256;
  localparam int unsigned MAX_CYCLES = 4000000;
  localparam int unsigned SETTLE_CYCLES = 4 * CAP + 40;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] cursor_pos;
    logic [8:0] line_length;
    logic [7:0] char_out;
  } edit_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [3:0] operation_i = '0;
  logic [7:0] char_in_i = '0;
  logic [7:0] read_index_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [8:0] cursor_pos_o;
  logic [8:0] line_length_o;
  logic [7:0] char_out_o;

  // Shadow copy of the editor state
  logic [7:0] line_mem [CAP];
  logic [7:0] kill_mem [CAP];
  int unsigned line_len_q;
  int unsigned cursor_q;
  int unsigned kill_len_q;
  bit          overtype_off;

  edit_result_t expected_results [$];
  int unsigned  fail_count;
  int unsigned  cycle_count;
  int unsigned  hold_cnt;
  bit           stall_busy;

  line_edit_buffer_core #(.LINE_CAP(CAP)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .operation_i, .char_in_i, .read_index_i,
    .out_valid_o, .out_stall_i, .status_o, .cursor_pos_o, .line_length_o, .char_out_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic bit is_word(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic int unsigned word_start(int unsigned pos);
    while (pos > 0 && !is_word(line_mem[pos-1])) pos--;
    while (pos > 0 && is_word(line_mem[pos-1])) pos--;
    return pos;
  endfunction

  // Move line[from..to) into the kill store and close the gap
  function automatic void cut_text(int unsigned from, int unsigned to);
    int unsigned n;
    n = to - from;
    for (int unsigned i = 0; i < n; i++) kill_mem[i] = line_mem[from+i];
    kill_len_q = n;
    for (int unsigned i = from; i + n < line_len_q; i++) line_mem[i] = line_mem[i+n];
    line_len_q -= n;
    cursor_q = from;
  endfunction

  // Apply one command to the shadow state and return its result
  function automatic edit_result_t apply_edit(leb_pkg::op_e op, logic [7:0] ch,
                                              logic [7:0] ridx);
    edit_result_t r;
    leb_pkg::status_e st;
    logic [7:0] t;
    logic [7:0] cout;
    st = leb_pkg::ST_OK;
    cout = '0;
    case (op)
      leb_pkg::OP_INSERT: begin
        if (overtype_off || cursor_q >= line_len_q) begin
          if (line_len_q >= CAP) st = leb_pkg::ST_FULL;
          else begin
            for (int i = line_len_q; i > int'(cursor_q); i--) line_mem[i] = line_mem[i-1];
            line_len_q++;
          end
        end
        if (st == leb_pkg::ST_OK) begin
          line_mem[cursor_q] = ch;
          cursor_q++;
        end
      end
      leb_pkg::OP_DEL_BACK: begin
        if (cursor_q == 0) st = leb_pkg::ST_REFUSED;
        else begin
          for (int unsigned i = cursor_q - 1; i + 1 < line_len_q; i++)
            line_mem[i] = line_mem[i+1];
          line_len_q--;
          cursor_q--;
        end
      end
      leb_pkg::OP_DEL_FWD: begin
        if (cursor_q >= line_len_q) st = leb_pkg::ST_REFUSED;
        else begin
          for (int unsigned i = cursor_q; i + 1 < line_len_q; i++)
            line_mem[i] = line_mem[i+1];
          line_len_q--;
        end
      end
      leb_pkg::OP_TRANSPOSE: begin
        if (line_len_q < 2) st = leb_pkg::ST_REFUSED;
        else if (cursor_q >= line_len_q) begin
          t = line_mem[line_len_q-2];
          line_mem[line_len_q-2] = line_mem[line_len_q-1];
          line_mem[line_len_q-1] = t;
        end else if (cursor_q > 0) begin
          t = line_mem[cursor_q-1];
          line_mem[cursor_q-1] = line_mem[cursor_q];
          line_mem[cursor_q] = t;
          cursor_q++;
        end else st = leb_pkg::ST_REFUSED;
      end
      leb_pkg::OP_LEFT: if (cursor_q == 0) st = leb_pkg::ST_REFUSED; else cursor_q--;
      leb_pkg::OP_RIGHT: begin
        if (cursor_q >= line_len_q) st = leb_pkg::ST_REFUSED;
        else cursor_q++;
      end
      leb_pkg::OP_HOME: cursor_q = 0;
      leb_pkg::OP_END: cursor_q = line_len_q;
      leb_pkg::OP_WORD_LEFT: begin
        if (cursor_q == 0) st = leb_pkg::ST_REFUSED;
        else cursor_q = word_start(cursor_q);
      end
      leb_pkg::OP_WORD_RIGHT: begin
        if (cursor_q >= line_len_q) st = leb_pkg::ST_REFUSED;
        else begin
          while (cursor_q < line_len_q && is_word(line_mem[cursor_q])) cursor_q++;
          while (cursor_q < line_len_q && !is_word(line_mem[cursor_q])) cursor_q++;
        end
      end
      leb_pkg::OP_KILL_END: begin
        for (int unsigned i = cursor_q; i < line_len_q; i++) kill_mem[i-cursor_q] = line_mem[i];
        kill_len_q = line_len_q - cursor_q;
        line_len_q = cursor_q;
      end
      leb_pkg::OP_KILL_START: if (cursor_q != 0) cut_text(0, cursor_q);
      leb_pkg::OP_KILL_WORD: begin
        if (cursor_q == 0) st = leb_pkg::ST_REFUSED;
        else cut_text(word_start(cursor_q), cursor_q);
      end
      leb_pkg::OP_YANK: begin
        if (kill_len_q == 0) st = leb_pkg::ST_REFUSED;
        else if (kill_len_q > CAP - line_len_q) st = leb_pkg::ST_FULL;
        else begin
          for (int i = int'(line_len_q) - 1; i >= int'(cursor_q); i--)
            line_mem[i+kill_len_q] = line_mem[i];
          for (int unsigned i = 0; i < kill_len_q; i++) line_mem[cursor_q+i] = kill_mem[i];
          line_len_q += kill_len_q;
          cursor_q += kill_len_q;
        end
      end
      leb_pkg::OP_CLEAR: begin
        line_len_q = 0;
        cursor_q = 0;
      end
      default: begin
        if (ridx < line_len_q) cout = line_mem[ridx];
        else st = leb_pkg::ST_REFUSED;
      end
    endcase
    r.status = st;
    r.cursor_pos = cursor_q[8:0];
    r.line_length = line_len_q[8:0];
    r.char_out = cout;
    return r;
  endfunction

  // Send one command; valid stays up across back-to-back transfers
  task automatic send_edit(leb_pkg::op_e op, logic [7:0] ch, logic [7:0] ridx);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    char_in_i <= ch;
    read_index_i <= ridx;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(apply_edit(op, ch, ridx));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(bit mode);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    overtype_off = mode;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0: return " ";
      1: return 8'($urandom_range(0, 255));
      2: return "_";
      3: return 8'($urandom_range("0", "9"));
      default: return 8'($urandom_range("a", "z"));
    endcase
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    edit_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time,
                 {status_o, cursor_pos_o, line_length_o, char_out_o});
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, status_o);
          fail_count++;
        end
        if (cursor_pos_o !== want.cursor_pos) begin
          $display("%0t: cursor exp %0d got %0d", $time, want.cursor_pos, cursor_pos_o);
          fail_count++;
        end
        if (line_length_o !== want.line_length) begin
          $display("%0t: length exp %0d got %0d", $time, want.line_length, line_length_o);
          fail_count++;
        end
        if (char_out_o !== want.char_out) begin
          $display("%0t: char exp %h got %h", $time, want.char_out, char_out_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall: draw a hold count after each transfer and stall until it runs down
  always @(posedge clk_i) begin
    if (stall_busy) begin
      out_stall_i <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      hold_cnt = $urandom_range(0, 5);
      out_stall_i <= (hold_cnt != 0);
    end else if (out_stall_i) begin
      if (hold_cnt > 0) hold_cnt--;
      out_stall_i <= (hold_cnt != 0);
    end
  end

  task automatic test_basic_edits();
    send_edit(leb_pkg::OP_DEL_BACK, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_DEL_FWD, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_TRANSPOSE, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_LEFT, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_RIGHT, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_WORD_LEFT, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_WORD_RIGHT, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_KILL_WORD, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_YANK, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_KILL_START, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_INSERT, 8'hFF, 8'hFF);
    send_edit(leb_pkg::OP_INSERT, "a", 8'h00);
    send_edit(leb_pkg::OP_INSERT, " ", 8'h00);
    send_edit(leb_pkg::OP_INSERT, "Z", 8'h00);
    send_edit(leb_pkg::OP_TRANSPOSE, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_HOME, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_RIGHT, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_TRANSPOSE, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_READ, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_READ, 8'h00, 8'hFF);
    send_edit(leb_pkg::OP_WORD_RIGHT, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_END, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_KILL_WORD, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_YANK, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_KILL_END, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_CLEAR, 8'h00, 8'h00);
  endtask

  // Fill to capacity, then push against the limit
  task automatic test_full_line();
    repeat (CAP) send_edit(leb_pkg::OP_INSERT, pick_char(), 8'h00);
    send_edit(leb_pkg::OP_INSERT, "x", 8'h00);
    send_edit(leb_pkg::OP_READ, 8'h00, 8'hFF);
    send_edit(leb_pkg::OP_LEFT, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_KILL_END, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_INSERT, "q", 8'h00);
    send_edit(leb_pkg::OP_YANK, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_DEL_BACK, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_YANK, 8'h00, 8'h00);
    send_edit(leb_pkg::OP_CLEAR, 8'h00, 8'h00);
  endtask

  task automatic test_random_edits(int unsigned count);
    leb_pkg::op_e op;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 4) op = leb_pkg::OP_INSERT;
      else op = leb_pkg::op_e'($urandom_range(1, 15));
      if (op == leb_pkg::OP_CLEAR && $urandom_range(0, 3) != 0) op = leb_pkg::OP_INSERT;
      send_edit(op, pick_char(), 8'($urandom_range(0, line_len_q + 2)));
      if (i == count / 2) begin
        // Hold the sender until the pipe is empty
        in_valid_i <= 1'b0;
        while (expected_results.size() > 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    stall_busy = 1'b0;
    line_len_q = 0;
    cursor_q = 0;
    kill_len_q = 0;
    overtype_off = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_edits();
    write_mode(1'b0);
    test_basic_edits();
    test_full_line();
    test_random_edits(200);
    write_mode(1'b1);
    test_random_edits(200);
    stall_busy = 1'b1;
    test_random_edits(100);
    stall_busy = 1'b0;
    write_mode(1'b0);
    test_random_edits(132);
    drain_results();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: line_edit_buffer_core.f
src/leb_pkg.sv
src/leb_ram.sv
src/line_edit_buffer_core.sv
bench/line_edit_buffer_core_tb.sv
